// ===== rtl/pidsc_pkg.sv =====
// ----------------------------------------------------------------------------
// pidsc_pkg
// shared constants, codes and types of the steering controller
// ----------------------------------------------------------------------------
package pidsc_pkg;

	localparam int unsigned CRUISE_FREQ = 256;
	localparam int unsigned CRUISE_AMP  = 7680;
	localparam int unsigned TIMEOUT_MS  = 500;

	localparam int unsigned MUL_A_W   = 32;
	localparam int unsigned MUL_B_W   = 16;
	localparam int unsigned PROD_W    = MUL_A_W + MUL_B_W;
	localparam int unsigned DEN_W     = 17;
	localparam int unsigned ACC_W     = 44;
	localparam int unsigned MUL_CNT_W = 5;
	localparam int unsigned DIV_CNT_W = 6;

	typedef enum logic [1:0] {
		OP_START  = 2'd0,
		OP_STOP   = 2'd1,
		OP_UPDATE = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		REG_CROSS_KP   = 3'd0,
		REG_CROSS_KI   = 3'd1,
		REG_CROSS_KD   = 3'd2,
		REG_HEADING_KP = 3'd3,
		REG_CURVE_GAIN = 3'd4,
		REG_MAX_BIAS   = 3'd5,
		REG_STOP_DIST  = 3'd6,
		REG_SLOW_DIST  = 3'd7
	} reg_index_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_status_t;

endpackage

// ===== rtl/pidsc_mul.sv =====
// ----------------------------------------------------------------------------
// pidsc_mul
// bit-serial shift-add multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
module pidsc_mul import pidsc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [MUL_A_W-1:0]  a,
	input  logic [MUL_B_W-1:0]  b,
	output logic [PROD_W-1:0]   product,
	output unit_status_t        status
);

	logic [MUL_A_W-1:0]   a_q;
	logic [PROD_W-1:0]    pr_q;
	logic [MUL_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [MUL_A_W:0]     sum_w;

	assign sum_w = {1'b0, pr_q[PROD_W-1:MUL_B_W]} + {1'b0, (pr_q[0] ? a_q : '0)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= MUL_CNT_W'(MUL_B_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == MUL_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q  <= a;
			pr_q <= {{MUL_A_W{1'b0}}, b};
		end else if (busy_q) begin
			pr_q <= {sum_w, pr_q[MUL_B_W-1:1]};
		end
	end

	assign product     = pr_q;
	assign status.busy = busy_q;
	assign status.done = done_q;

endmodule

// ===== rtl/pidsc_div.sv =====
// ----------------------------------------------------------------------------
// pidsc_div
// restoring radix-2 divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module pidsc_div import pidsc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [PROD_W-1:0]   num,
	input  logic [DEN_W-1:0]    den,
	output logic [PROD_W-1:0]   quotient,
	output unit_status_t        status
);

	logic [PROD_W-1:0]    dv_q;
	logic [DEN_W-1:0]     rem_q;
	logic [DEN_W-1:0]     den_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DEN_W:0]       r2_w;
	logic [DEN_W:0]       sub_w;
	logic                 ge_w;

	assign r2_w  = {rem_q, dv_q[PROD_W-1]};
	assign ge_w  = r2_w >= {1'b0, den_q};
	assign sub_w = r2_w - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(PROD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dv_q  <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			dv_q  <= {dv_q[PROD_W-2:0], ge_w};
			rem_q <= ge_w ? sub_w[DEN_W-1:0] : r2_w[DEN_W-1:0];
		end
	end

	assign quotient    = dv_q;
	assign status.busy = busy_q;
	assign status.done = done_q;

endmodule

// ===== rtl/pid_steering_speed_controller.sv =====
// ----------------------------------------------------------------------------
// pid_steering_speed_controller
// session-gated pid steering with curvature feed-forward and distance scaling
// start, stop and rejected items: decided in ST_EVAL, result registered from ST_FIN
// accepted update: nine passes of the serial multiplier and four passes of the
//   serial divider, run in sequence
// one item in flight; the next item is taken once the result is registered
// asynchronous active-low reset: registers at defaults, no session active
// ----------------------------------------------------------------------------
module pid_steering_speed_controller import pidsc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [15:0] session_tag,
	input  logic [31:0] now_ms,
	input  logic [31:0] sequence_req,
	input  logic signed [15:0] cross_track_error,
	input  logic signed [15:0] heading_error,
	input  logic signed [15:0] curvature,
	input  logic [15:0] target_distance,
	input  logic        brake_request,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        accepted,
	output logic        stop_flag,
	output logic [10:0] frequency,
	output logic [13:0] amplitude,
	output logic signed [14:0] bias,
	output logic        timed_out,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_wdata
);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_EVAL   = 6'b000010,
		ST_LAUNCH = 6'b000100,
		ST_MUL    = 6'b001000,
		ST_DIV    = 6'b010000,
		ST_FIN    = 6'b100000
	} state_t;

	typedef enum logic [8:0] {
		PH_EDT = 9'b000000001,
		PH_KP  = 9'b000000010,
		PH_KI  = 9'b000000100,
		PH_KD1 = 9'b000001000,
		PH_KD2 = 9'b000010000,
		PH_HD  = 9'b000100000,
		PH_CV  = 9'b001000000,
		PH_FQ  = 9'b010000000,
		PH_AM  = 9'b100000000
	} phase_t;

	state_t state_q;
	phase_t phase_q;

	logic [15:0] kp_q, ki_q, kd_q, hkp_q, cg_q, stop_q, slow_q;
	logic [13:0] maxb_q;

	logic        sa_q, hu_q;
	logic [15:0] cur_tag_q;
	logic [31:0] last_seq_q, last_time_q;
	logic signed [15:0] integ_q, prior_q;

	logic [1:0]  op_q;
	logic [15:0] tag_q, dist_q;
	logic [31:0] now_q, seq_q;
	logic signed [15:0] e_q, head_q, curv_q;
	logic        brake_q;

	logic [8:0]       dt_q;
	logic [31:0]      tmp_q;
	logic [ACC_W-1:0] acc_q;

	logic        res_acc_q, res_stop_q, res_to_q;
	logic [10:0] res_freq_q;
	logic [13:0] res_amp_q;
	logic [14:0] res_bias_q;

	logic        out_valid_q, accepted_q, stop_flag_q, timed_out_q;
	logic [10:0] frequency_q;
	logic [13:0] amplitude_q;
	logic [14:0] bias_q;

	logic               mul_start, div_start;
	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [PROD_W-1:0]  product, quotient, div_num;
	logic [DEN_W-1:0]   div_den;
	unit_status_t       mul_st, div_st;

	pidsc_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       (mul_a),
		.b       (mul_b),
		.product (product),
		.status  (mul_st)
	);

	pidsc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.num      (div_num),
		.den      (div_den),
		.quotient (quotient),
		.status   (div_st)
	);

	// operand magnitudes
	logic [15:0] e_mag, head_mag, curv_mag, integ_mag, diff_mag;
	logic signed [16:0] diff_w;
	logic [16:0] diff_abs;

	assign e_mag     = e_q[15] ? (~e_q + 16'd1) : e_q;
	assign head_mag  = head_q[15] ? (~head_q + 16'd1) : head_q;
	assign curv_mag  = curv_q[15] ? (~curv_q + 16'd1) : curv_q;
	assign integ_mag = integ_q[15] ? (~integ_q + 16'd1) : integ_q;
	assign diff_w    = {e_q[15], e_q} - {prior_q[15], prior_q};
	assign diff_abs  = diff_w[16] ? (~diff_w + 17'd1) : diff_w;
	assign diff_mag  = diff_abs[15:0];

	// distance scale
	logic        dist_ge, dist_quarter;
	logic [15:0] sc_num, sc_den;

	assign dist_ge      = dist_q >= slow_q;
	assign dist_quarter = {dist_q, 2'b00} < {2'b00, slow_q};

	always_comb begin
		if (dist_ge) begin
			sc_num = 16'd1;
			sc_den = 16'd1;
		end else if (dist_quarter) begin
			sc_num = 16'd1;
			sc_den = 16'd4;
		end else begin
			sc_num = dist_q;
			sc_den = slow_q;
		end
	end

	logic needs_div;

	always_comb begin
		mul_a     = '0;
		mul_b     = '0;
		div_num   = product;
		div_den   = DEN_W'(1);
		needs_div = 1'b0;
		case (phase_q)
			PH_EDT: begin
				mul_a     = {16'b0, e_mag};
				mul_b     = {7'b0, dt_q};
				div_num   = product + PROD_W'(500);
				div_den   = DEN_W'(1000);
				needs_div = 1'b1;
			end
			PH_KP: begin
				mul_a = {16'b0, kp_q};
				mul_b = e_mag;
			end
			PH_KI: begin
				mul_a = {16'b0, ki_q};
				mul_b = integ_mag;
			end
			PH_KD1: begin
				mul_a = {16'b0, kd_q};
				mul_b = diff_mag;
			end
			PH_KD2: begin
				mul_a     = tmp_q;
				mul_b     = MUL_B_W'(1000);
				div_num   = product + {{(PROD_W-8){1'b0}}, dt_q[8:1]};
				div_den   = {8'b0, dt_q};
				needs_div = 1'b1;
			end
			PH_HD: begin
				mul_a = {16'b0, hkp_q};
				mul_b = head_mag;
			end
			PH_CV: begin
				mul_a = {16'b0, cg_q};
				mul_b = curv_mag;
			end
			PH_FQ: begin
				mul_a     = {16'b0, sc_num};
				mul_b     = MUL_B_W'(2 * CRUISE_FREQ);
				div_num   = product + {{(PROD_W-16){1'b0}}, sc_den};
				div_den   = {sc_den, 1'b0};
				needs_div = 1'b1;
			end
			PH_AM: begin
				mul_a     = {16'b0, sc_num};
				mul_b     = MUL_B_W'(2 * CRUISE_AMP);
				div_num   = product + {{(PROD_W-16){1'b0}}, sc_den};
				div_den   = {sc_den, 1'b0};
				needs_div = 1'b1;
			end
			default: begin
				mul_a = '0;
			end
		endcase
	end

	logic wb_en;
	logic [PROD_W-1:0] wb_val;

	assign mul_start = (state_q == ST_LAUNCH);
	assign div_start = (state_q == ST_MUL) && mul_st.done && needs_div;
	assign wb_en     = ((state_q == ST_MUL) && mul_st.done && !needs_div) ||
	                   ((state_q == ST_DIV) && div_st.done);
	assign wb_val    = (state_q == ST_DIV) ? quotient : product;

	// signed accumulation of one term
	logic             term_neg;
	logic [ACC_W-1:0] term_mag, acc_next;

	always_comb begin
		term_mag = {1'b0, wb_val[ACC_W-2:0]};
		term_neg = 1'b0;
		case (phase_q)
			PH_KP:   term_neg = e_q[15];
			PH_KI:   term_neg = integ_q[15];
			PH_KD2:  term_neg = diff_w[16];
			PH_HD: begin
				term_neg = head_q[15];
				term_mag = {1'b0, wb_val[ACC_W-6:0], 4'b0};
			end
			PH_CV:   term_neg = curv_q[15];
			default: term_neg = 1'b0;
		endcase
		acc_next = acc_q + (term_neg ? (~term_mag + 1'b1) : term_mag);
	end

	// integral update
	logic [14:0]        q_edt;
	logic signed [16:0] integ_sum;
	logic signed [15:0] integ_clip;

	assign q_edt     = wb_val[14:0];
	assign integ_sum = {integ_q[15], integ_q} +
	                   (e_q[15] ? -$signed({2'b00, q_edt}) : $signed({2'b00, q_edt}));

	always_comb begin
		if (integ_sum > 17'sd8192)
			integ_clip = 16'sd8192;
		else if (integ_sum < -17'sd8192)
			integ_clip = -16'sd8192;
		else
			integ_clip = integ_sum[15:0];
	end

	// frequency and amplitude limits
	logic [10:0] freq_clip;
	logic [13:0] amp_clip;

	always_comb begin
		if (wb_val < PROD_W'(77))
			freq_clip = 11'd77;
		else if (wb_val > PROD_W'(1280))
			freq_clip = 11'd1280;
		else
			freq_clip = wb_val[10:0];
		if (wb_val < PROD_W'(1536))
			amp_clip = 14'd1536;
		else if (wb_val > PROD_W'(12800))
			amp_clip = 14'd12800;
		else
			amp_clip = wb_val[13:0];
	end

	// bias rounding and limit
	logic [ACC_W-1:0] acc_mag, acc_rnd;
	logic [31:0]      bias_mag;
	logic [13:0]      bias_clip;
	logic [14:0]      bias_w;
	logic             stop_w;

	assign acc_mag   = acc_q[ACC_W-1] ? (~acc_q + 1'b1) : acc_q;
	assign acc_rnd   = acc_mag + ACC_W'(2048);
	assign bias_mag  = acc_rnd[ACC_W-1:12];
	assign bias_clip = (bias_mag > {18'b0, maxb_q}) ? maxb_q : bias_mag[13:0];
	assign bias_w    = acc_q[ACC_W-1] ? (~{1'b0, bias_clip} + 15'd1) : {1'b0, bias_clip};
	assign stop_w    = brake_q && (dist_q <= stop_q);

	// decode of a new item
	logic [31:0] delta_w;
	logic [8:0]  dt_w;
	logic        to_w, upd_ok, start_ok;

	assign delta_w  = now_q - last_time_q;
	assign to_w     = sa_q && (delta_w >= 32'(TIMEOUT_MS));
	assign upd_ok   = sa_q && (tag_q == cur_tag_q) && !(hu_q && (seq_q <= last_seq_q));
	assign start_ok = (op_q == OP_START) && (tag_q != 16'd0);

	always_comb begin
		if (!hu_q)
			dt_w = 9'd100;
		else if (delta_w < 32'd10)
			dt_w = 9'd10;
		else if (delta_w > 32'd500)
			dt_w = 9'd500;
		else
			dt_w = delta_w[8:0];
	end

	logic out_load;

	assign out_load = (state_q == ST_FIN) && (!out_valid_q || out_ready);
	assign in_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= PH_EDT;
			kp_q        <= 16'd256;
			ki_q        <= 16'd0;
			kd_q        <= 16'd0;
			hkp_q       <= 16'd256;
			cg_q        <= 16'd0;
			maxb_q      <= 14'd5120;
			stop_q      <= 16'd77;
			slow_q      <= 16'd256;
			sa_q        <= 1'b0;
			hu_q        <= 1'b0;
			cur_tag_q   <= '0;
			last_seq_q  <= '0;
			last_time_q <= '0;
			integ_q     <= '0;
			prior_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (reg_index_t'(cfg_index))
					REG_CROSS_KP:   kp_q  <= cfg_wdata;
					REG_CROSS_KI:   ki_q  <= cfg_wdata;
					REG_CROSS_KD:   kd_q  <= cfg_wdata;
					REG_HEADING_KP: hkp_q <= cfg_wdata;
					REG_CURVE_GAIN: cg_q  <= cfg_wdata;
					REG_MAX_BIAS: begin
						if (cfg_wdata >= 16'd1 && cfg_wdata <= 16'd11520)
							maxb_q <= cfg_wdata[13:0];
					end
					REG_STOP_DIST: begin
						if (cfg_wdata <= 16'd65534 && slow_q > cfg_wdata)
							stop_q <= cfg_wdata;
					end
					REG_SLOW_DIST: begin
						if (cfg_wdata >= 16'd1 && cfg_wdata > stop_q)
							slow_q <= cfg_wdata;
					end
					default: kp_q <= kp_q;
				endcase
			end

			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (in_valid)
						state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					res_acc_q  <= start_ok;
					res_stop_q <= 1'b0;
					res_freq_q <= '0;
					res_amp_q  <= '0;
					res_bias_q <= '0;
					res_to_q   <= (start_ok || op_q == OP_STOP) ? 1'b0 : to_w;
					state_q    <= (op_q == OP_UPDATE && upd_ok) ? ST_LAUNCH : ST_FIN;
					case (op_t'(op_q))
						OP_START: begin
							if (start_ok) begin
								sa_q        <= 1'b1;
								hu_q        <= 1'b0;
								cur_tag_q   <= tag_q;
								last_seq_q  <= '0;
								last_time_q <= now_q;
								integ_q     <= '0;
								prior_q     <= '0;
							end
						end
						OP_STOP: begin
							sa_q      <= 1'b0;
							cur_tag_q <= '0;
							integ_q   <= '0;
						end
						OP_UPDATE: begin
							if (upd_ok) begin
								dt_q    <= dt_w;
								acc_q   <= '0;
								phase_q <= PH_EDT;
							end
						end
						default: ;
					endcase
				end
				ST_LAUNCH: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					if (mul_st.done)
						state_q <= needs_div ? ST_DIV : ST_LAUNCH;
				end
				ST_DIV: begin
					if (div_st.done)
						state_q <= (phase_q == PH_AM) ? ST_FIN : ST_LAUNCH;
				end
				ST_FIN: begin
					if (out_load)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase

			if (wb_en) begin
				case (phase_q)
					PH_EDT: begin
						integ_q <= integ_clip;
						phase_q <= PH_KP;
					end
					PH_KP: begin
						acc_q   <= acc_next;
						phase_q <= PH_KI;
					end
					PH_KI: begin
						acc_q   <= acc_next;
						phase_q <= PH_KD1;
					end
					PH_KD1: begin
						tmp_q   <= wb_val[31:0];
						phase_q <= PH_KD2;
					end
					PH_KD2: begin
						acc_q   <= acc_next;
						phase_q <= PH_HD;
					end
					PH_HD: begin
						acc_q   <= acc_next;
						phase_q <= PH_CV;
					end
					PH_CV: begin
						acc_q   <= acc_next;
						phase_q <= PH_FQ;
					end
					PH_FQ: begin
						res_freq_q <= freq_clip;
						phase_q    <= PH_AM;
					end
					PH_AM: begin
						res_acc_q   <= 1'b1;
						res_stop_q  <= stop_w;
						res_to_q    <= 1'b0;
						res_amp_q   <= stop_w ? 14'd0 : amp_clip;
						res_bias_q  <= stop_w ? 15'd0 : bias_w;
						if (stop_w)
							res_freq_q <= '0;
						last_seq_q  <= seq_q;
						last_time_q <= now_q;
						prior_q     <= e_q;
						hu_q        <= 1'b1;
						phase_q     <= PH_EDT;
					end
					default: phase_q <= PH_EDT;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q    <= operation;
			tag_q   <= session_tag;
			now_q   <= now_ms;
			seq_q   <= sequence_req;
			e_q     <= cross_track_error;
			head_q  <= heading_error;
			curv_q  <= curvature;
			dist_q  <= target_distance;
			brake_q <= brake_request;
		end
		if (out_load) begin
			accepted_q  <= res_acc_q;
			stop_flag_q <= res_stop_q;
			frequency_q <= res_freq_q;
			amplitude_q <= res_amp_q;
			bias_q      <= res_bias_q;
			timed_out_q <= res_to_q;
		end
	end

	assign out_valid = out_valid_q;
	assign accepted  = accepted_q;
	assign stop_flag = stop_flag_q;
	assign frequency = frequency_q;
	assign amplitude = amplitude_q;
	assign bias      = bias_q;
	assign timed_out = timed_out_q;

	a_mul_done_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		mul_st.done |-> state_q == ST_MUL)
		else $error("multiplier finished outside its run state");

	a_div_done_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		div_st.done |-> state_q == ST_DIV)
		else $error("divider finished outside its run state");

	a_stop_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && stop_flag_q |-> frequency_q == 11'd0 && amplitude_q == 14'd0
			&& bias_q == 15'd0)
		else $error("stop result carries nonzero outputs");

	a_dist_order: assert property (@(posedge clk) disable iff (!arst_n)
		slow_q > stop_q)
		else $error("slow distance not above stop distance");

	a_integ_range: assert property (@(posedge clk) disable iff (!arst_n)
		integ_q <= 16'sd8192 && integ_q >= -16'sd8192)
		else $error("integral left its limit");

endmodule

// ===== verif/pid_steering_speed_controller_tb.sv =====
// ----------------------------------------------------------------------------
// pid_steering_speed_controller_tb
// Drives session start, stop and update items through the valid/ready input
// channel. Gains and distance limits are changed between phases. A built-in
// model of the controller predicts each result, and every result is compared
// field by field in arrival order. Both channels idle at random, and one
// long output stall backs the controller up.
// ----------------------------------------------------------------------------
module pid_steering_speed_controller_tb;
	import pidsc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int unsigned STALL_LIMIT = 8000;

	typedef struct {
		logic [1:0]         op;
		logic [15:0]        tag;
		logic [31:0]        now;
		logic [31:0]        seq;
		logic signed [15:0] cte;
		logic signed [15:0] head;
		logic signed [15:0] curv;
		logic [15:0]        tdist;
		logic               brake;
	} steer_item_t;

	typedef struct {
		logic               acc;
		logic               stopf;
		logic [10:0]        freq;
		logic [13:0]        amp;
		logic signed [14:0] bias;
		logic               tmo;
	} steer_result_t;

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	logic [1:0] operation;
	logic [15:0] session_tag, target_distance;
	logic [31:0] now_ms, sequence_req;
	logic signed [15:0] cross_track_error, heading_error, curvature;
	logic brake_request, accepted, stop_flag, timed_out;
	logic [10:0] frequency;
	logic [13:0] amplitude;
	logic signed [14:0] bias;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [15:0] cfg_wdata;

	pid_steering_speed_controller uut (.*);

	// model of the controller
	longint unsigned g_kp, g_ki, g_kd, g_hk, g_cg, g_maxb, g_stopd, g_slowd;
	bit m_active, m_have;
	logic [15:0] m_tag;
	logic [31:0] m_seq, m_time;
	longint m_integ, m_prior;

	steer_result_t expected_q[$];
	int errors;
	bit idle_on;
	int hold_request;
	int unsigned quiet_cycles;
	int stall_left, hold_left;
	logic [15:0] cur_tag;
	logic [31:0] cur_now, cur_seq;

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	function automatic longint rnd_div(longint n, longint d);
		if (n >= 0)
			return (n + d / 2) / d;
		return -((-n + d / 2) / d);
	endfunction

	function automatic longint clampv(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint cruise_scaled(longint unsigned base, longint unsigned d);
		longint unsigned num, den;
		if (d >= g_slowd) begin
			num = 1; den = 1;
		end else if (4 * d < g_slowd) begin
			num = 1; den = 4;
		end else begin
			num = d; den = g_slowd;
		end
		return longint'((2 * base * num + den) / (2 * den));
	endfunction

	function automatic steer_result_t predict_steering(steer_item_t it);
		steer_result_t r;
		longint e, dt, integ, sum;
		logic [31:0] since;
		r = '{default: '0};
		e = it.cte;
		case (it.op)
			OP_START: begin
				if (it.tag != 0) begin
					m_active = 1; m_have = 0; m_tag = it.tag; m_seq = 0;
					m_time = it.now; m_integ = 0; m_prior = 0; r.acc = 1;
				end
			end
			OP_STOP: begin
				m_active = 0; m_tag = 0; m_integ = 0;
			end
			OP_UPDATE: begin
				if (m_active && it.tag == m_tag && !(m_have && it.seq <= m_seq)) begin
					dt = 100;
					if (m_have)
						dt = clampv(longint'(32'(it.now - m_time)), 10, 500);
					integ = clampv(m_integ + rnd_div(e * dt, 1000), -8192, 8192);
					m_integ = integ;
					sum = longint'(g_kp) * e + longint'(g_ki) * integ
						+ rnd_div(longint'(g_kd) * (e - m_prior) * 1000, dt)
						+ longint'(g_hk) * longint'(it.head) * 16
						+ longint'(g_cg) * longint'(it.curv);
					r.stopf = it.brake && (it.tdist <= g_stopd);
					if (!r.stopf) begin
						r.bias = 15'(clampv(rnd_div(sum, 4096), -longint'(g_maxb),
							longint'(g_maxb)));
						r.freq = 11'(clampv(cruise_scaled(CRUISE_FREQ, it.tdist), 77, 1280));
						r.amp = 14'(clampv(cruise_scaled(CRUISE_AMP, it.tdist), 1536, 12800));
					end
					m_seq = it.seq; m_time = it.now; m_prior = e; m_have = 1;
					r.acc = 1;
				end
			end
			default: ;
		endcase
		since = it.now - m_time;
		r.tmo = m_active && (since >= TIMEOUT_MS);
		return r;
	endfunction

	task automatic send_item(steer_item_t it);
		int gap;
		gap = idle_on ? $urandom_range(0, 15) : 0;
		if (gap > 0) begin
			@(negedge clk) in_valid <= 0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		operation <= it.op; session_tag <= it.tag; now_ms <= it.now;
		sequence_req <= it.seq; cross_track_error <= it.cte; heading_error <= it.head;
		curvature <= it.curv; target_distance <= it.tdist; brake_request <= it.brake;
		in_valid <= 1;
		do @(posedge clk); while (!in_ready);
		expected_q.push_back(predict_steering(it));
	endtask

	task automatic write_reg(reg_index_t idx, logic [15:0] val);
		@(negedge clk);
		in_valid <= 0;
		cfg_we <= 1; cfg_index <= idx; cfg_wdata <= val;
		@(negedge clk) cfg_we <= 0;
		case (idx)
			REG_CROSS_KP:   g_kp = val;
			REG_CROSS_KI:   g_ki = val;
			REG_CROSS_KD:   g_kd = val;
			REG_HEADING_KP: g_hk = val;
			REG_CURVE_GAIN: g_cg = val;
			REG_MAX_BIAS:   if (val >= 1 && val <= 11520) g_maxb = val;
			REG_STOP_DIST:  if (val <= 65534 && g_slowd > val) g_stopd = val;
			REG_SLOW_DIST:  if (val >= 1 && val > g_stopd) g_slowd = val;
			default: ;
		endcase
	endtask

	task automatic wait_idle();
		@(negedge clk) in_valid <= 0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	function automatic steer_item_t make_update(bit noisy);
		steer_item_t it;
		int pick;
		cur_now = cur_now + (($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 650));
		cur_seq = cur_seq + $urandom_range(1, 4);
		it.op = OP_UPDATE; it.tag = cur_tag; it.now = cur_now; it.seq = cur_seq;
		pick = $urandom_range(0, 3);
		it.cte = (pick == 0) ? 16'($urandom) : 16'(signed'(12'($urandom)));
		it.head = (pick == 1) ? 16'($urandom) : 16'(signed'(10'($urandom)));
		it.curv = 16'($urandom);
		it.tdist = ($urandom_range(0, 2) == 0) ? 16'($urandom)
			: 16'($urandom_range(0, 2 * g_slowd > 65535 ? 65535 : 2 * g_slowd));
		it.brake = $urandom_range(0, 1);
		if (noisy) begin
			case ($urandom_range(0, 4))
				0: it.op = OP_UNUSED;
				1: it.tag = cur_tag ^ 16'($urandom_range(1, 65535));
				2: it.seq = cur_seq - $urandom_range(0, 3);
				3: it.op = OP_STOP;
				default: it.seq = $urandom;
			endcase
		end
		return it;
	endfunction

	task automatic open_session(logic [15:0] tag);
		steer_item_t it;
		it = make_update(0);
		it.op = OP_START; it.tag = tag;
		cur_tag = tag; cur_seq = $urandom_range(0, 3) == 0 ? $urandom : 0;
		send_item(it);
	endtask

	task automatic run_sessions(int n);
		int sent;
		sent = 0;
		while (sent < n) begin
			open_session($urandom_range(0, 15) == 0 ? 16'd0 : 16'($urandom_range(1, 65535)));
			sent++;
			repeat ($urandom_range(3, 25)) begin
				send_item(make_update($urandom_range(0, 9) == 0));
				sent++;
			end
		end
	endtask

	task automatic test_directed();
		steer_item_t it;
		cur_now = 32'hFFFF_FF00;
		open_session(16'd0);
		open_session(16'hFFFF);
		it = make_update(0);
		it.cte = 16'sh7FFF; it.head = 16'sh7FFF; it.curv = 16'sh7FFF;
		it.tdist = 16'hFFFF; it.brake = 0;
		send_item(it);
		it = make_update(0);
		it.cte = -16'sh8000; it.head = -16'sh8000; it.curv = -16'sh8000;
		it.tdist = 16'd0; it.brake = 1;
		send_item(it);
		it = make_update(0); it.tdist = 16'd0; it.brake = 0; send_item(it);
		it = make_update(0); it.tdist = 16'd100; it.brake = 0; send_item(it);
		it = make_update(0); it.now = cur_now; send_item(it);
		it = make_update(0); it.now = cur_now + 32'd5000; send_item(it);
		it = make_update(0); it.seq = m_seq; send_item(it);
		it = make_update(0); it.tag = 16'd1; send_item(it);
		it = make_update(0); it.op = OP_UNUSED; send_item(it);
		it = make_update(0); it.op = OP_STOP; send_item(it);
		it = make_update(0); send_item(it);
		open_session(16'd1);
		cur_seq = 32'hFFFF_FFFE;
		send_item(make_update(0));
		send_item(make_update(0));
		it = make_update(0); it.now = m_time + 32'd700; send_item(it);
	endtask

	task automatic test_config_extremes();
		write_reg(REG_MAX_BIAS, 16'd0);
		write_reg(REG_MAX_BIAS, 16'd11521);
		write_reg(REG_MAX_BIAS, 16'd11520);
		write_reg(REG_CROSS_KP, 16'hFFFF);
		write_reg(REG_CROSS_KI, 16'hFFFF);
		write_reg(REG_CROSS_KD, 16'hFFFF);
		write_reg(REG_HEADING_KP, 16'hFFFF);
		write_reg(REG_CURVE_GAIN, 16'hFFFF);
		write_reg(REG_SLOW_DIST, 16'd0);
		write_reg(REG_STOP_DIST, 16'd256);
		write_reg(REG_SLOW_DIST, 16'hFFFF);
		write_reg(REG_STOP_DIST, 16'hFFFF);
		write_reg(REG_STOP_DIST, 16'hFFFE);
		write_reg(REG_SLOW_DIST, 16'd100);
		idle_on = 0;
		run_sessions(60);
		idle_on = 1;
		wait_idle();
		write_reg(REG_STOP_DIST, 16'd0);
		write_reg(REG_SLOW_DIST, 16'd1);
		write_reg(REG_MAX_BIAS, 16'd1);
		write_reg(REG_CROSS_KP, 16'd0);
		write_reg(REG_HEADING_KP, 16'd0);
		run_sessions(60);
		wait_idle();
	endtask

	task automatic test_random_gains();
		logic [15:0] sd;
		repeat (4) begin
			write_reg(REG_CROSS_KP, $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 1024)));
			write_reg(REG_CROSS_KI, $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 1024)));
			write_reg(REG_CROSS_KD, $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 64)));
			write_reg(REG_HEADING_KP, 16'($urandom_range(0, 1024)));
			write_reg(REG_CURVE_GAIN, 16'($urandom));
			write_reg(REG_MAX_BIAS, 16'($urandom_range(1, 11520)));
			sd = 16'($urandom_range(2, 65535));
			write_reg(REG_STOP_DIST, 16'd0);
			write_reg(REG_SLOW_DIST, sd);
			write_reg(REG_STOP_DIST, 16'($urandom_range(0, sd - 1)));
			run_sessions(135);
			wait_idle();
		end
	endtask

	task automatic test_output_backpressure();
		hold_request = 2500;
		open_session(16'($urandom_range(1, 65535)));
		repeat (20) send_item(make_update(0));
		wait_idle();
	endtask

	// receiver: random stalls, plus one long hold-off on request
	always @(negedge clk) begin
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ready <= 0;
		end else
			out_ready <= 1;
	end

	task automatic check_field(string name, longint exp_v, longint act_v);
		if (exp_v != act_v) begin
			errors++;
			$display("%0t %s mismatch: expected %0d actual %0d", $time, name, exp_v, act_v);
		end
	endtask

	always @(posedge clk) begin
		steer_result_t exp_r;
		if (arst_n && ((in_valid && in_ready) || (out_valid && out_ready)))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (arst_n && out_valid && out_ready) begin
			stall_left = idle_on ? $urandom_range(0, 15) : 0;
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t unexpected result: expected none actual accepted %0d bias %0d",
					$time, accepted, bias);
			end else begin
				exp_r = expected_q.pop_front();
				check_field("accepted", exp_r.acc, accepted);
				check_field("stop_flag", exp_r.stopf, stop_flag);
				check_field("frequency", exp_r.freq, frequency);
				check_field("amplitude", exp_r.amp, amplitude);
				check_field("bias", exp_r.bias, bias);
				check_field("timed_out", exp_r.tmo, timed_out);
			end
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		arst_n = 0;
		in_valid = 0; out_ready = 0; cfg_we = 0; cfg_index = '0; cfg_wdata = '0;
		operation = '0; session_tag = '0; now_ms = '0; sequence_req = '0;
		cross_track_error = '0; heading_error = '0; curvature = '0;
		target_distance = '0; brake_request = 0;
		errors = 0; idle_on = 1; hold_request = 0; quiet_cycles = 0;
		stall_left = 0; hold_left = 0;
		g_kp = 256; g_ki = 0; g_kd = 0; g_hk = 256; g_cg = 0;
		g_maxb = 5120; g_stopd = 77; g_slowd = 256;
		m_active = 0; m_have = 0; m_tag = 0; m_seq = 0; m_time = 0;
		m_integ = 0; m_prior = 0;
		cur_tag = 0; cur_now = 0; cur_seq = 0;
		repeat (3) @(posedge clk);
		@(negedge clk) arst_n = 1;
		test_directed();
		wait_idle();
		test_config_extremes();
		test_random_gains();
		test_output_backpressure();
		@(negedge clk) in_valid <= 0;
		wait_idle();
		repeat (400) @(posedge clk);
		errors += expected_q.size();
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/pidsc_pkg.sv
rtl/pidsc_mul.sv
rtl/pidsc_div.sv
rtl/pid_steering_speed_controller.sv
verif/pid_steering_speed_controller_tb.sv
